@@ sv/md5_pkg.sv @@
`timescale 1ns / 1ps
// md5_pkg: types, constants and round tables shared by the MD5 engine.
// No dependencies.
package md5_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       emit_digest;
        logic       restart_after;
    } md5_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_out_t;

    // request as it travels from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       absorb;
        logic       digest;
        logic       restart;
    } md5_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DSTART,
        ST_PREP,
        ST_RUN,
        ST_FIN,
        ST_EMIT
    } md5_state_t;

    typedef enum logic [1:0] {
        MD_BLOCK,
        MD_PAD1,
        MD_PAD2
    } md5_mode_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd56;
    localparam logic [3:0] LEN_LO_WRD = 4'd14;
    localparam logic [3:0] LEN_HI_WRD = 4'd15;
    localparam logic [1:0] LAST_WORD  = 2'd3;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] rot_amt(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // message word used by step i
    function automatic logic [3:0] msg_idx(input logic [5:0] i);
        logic [3:0] lo;
        logic [3:0] g;
        lo = i[3:0];
        case (i[5:4])
            2'd0:    g = lo;
            2'd1:    g = 4'(lo * 4'd5 + 4'd1);
            2'd2:    g = 4'(lo * 4'd3 + 4'd5);
            default: g = 4'(lo * 4'd7);
        endcase
        return g;
    endfunction

endpackage

@@ sv/md5_hash_engine_core.sv @@
`timescale 1ns / 1ps
// md5_hash_engine_core: MD5 engine top level, request queue plus compression back end.
// Depends on md5_pkg, md5_front, md5_back.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_item   (md5_in_t)
//  m_      | out       | m_valid / m_ready  | m_result (md5_out_t)
//
// A byte that completes a block: load, 64 steps, chaining add.
// A digest: one padding block, two when the message ends at byte 56 or later
// of its block, then four words via the output register, one per cycle unless stalled.
// Reset (aresetn low, synchronous) restores the initial chaining words and
// clears counts; no clearing pass. Either side may stall independently.
module md5_hash_engine_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  md5_pkg::md5_in_t   s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output md5_pkg::md5_out_t  m_result
);

    logic              cmd_valid;
    logic              cmd_pop;
    md5_pkg::md5_cmd_t cmd;

    md5_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    md5_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule

@@ sv/md5_front.sv @@
`timescale 1ns / 1ps
// md5_front: takes items, drops empty ones, queues requests for the engine.
// Depends on md5_pkg.
module md5_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  md5_pkg::md5_in_t   s_item,
    output logic               cmd_valid,
    input  logic               cmd_pop,
    output md5_pkg::md5_cmd_t  cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    md5_pkg::md5_cmd_t q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    md5_pkg::md5_cmd_t in_cmd;
    logic              keep;
    logic              push;

    always_comb begin
        in_cmd.data_byte = s_item.data_byte;
        in_cmd.absorb    = s_item.has_byte;
        in_cmd.digest    = s_item.emit_digest;
        in_cmd.restart   = s_item.restart_after & s_item.emit_digest;
        keep             = s_item.has_byte | s_item.emit_digest;
    end

    assign s_ready   = (count_reg != CW'(QUEUE_DEPTH));
    assign push      = s_valid & s_ready & keep;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && cmd_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("request queue overfilled");
`endif

endmodule

@@ sv/md5_back.sv @@
`timescale 1ns / 1ps
// md5_back: block buffer, 64-step compression, padding and digest output.
// Depends on md5_pkg.
module md5_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    input  md5_pkg::md5_cmd_t  cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output md5_pkg::md5_out_t  m_result
);

    md5_pkg::md5_state_t state_reg, state_next;
    md5_pkg::md5_mode_t  mode_reg;

    logic [31:0] buf_mem [16];
    logic [31:0] rd_data_reg;
    logic [3:0]  rd_addr;

    logic [31:0] cv_reg [4];
    logic [31:0] hv_reg [4];
    logic [31:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [63:0] bit_count_reg;
    logic [5:0]  fill_reg;
    logic [5:0]  round_reg;
    logic [1:0]  widx_reg;
    logic        emit_reg;
    logic        restart_reg;
    logic        m_valid_reg;
    md5_pkg::md5_out_t m_data_reg;

    logic        out_load;
    logic        block_full;
    logic [3:0]  g;
    logic [31:0] f;
    logic [31:0] m_word;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [31:0] new_b;
    logic        len_here;

    assign block_full = cmd.absorb && (fill_reg == md5_pkg::LAST_BYTE);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            md5_pkg::ST_IDLE: begin
                if (cmd_pop) begin
                    if (block_full) begin
                        state_next = md5_pkg::ST_PREP;
                    end else if (cmd.digest) begin
                        state_next = md5_pkg::ST_DSTART;
                    end
                end
            end
            md5_pkg::ST_DSTART: state_next = md5_pkg::ST_PREP;
            md5_pkg::ST_PREP:   state_next = md5_pkg::ST_RUN;
            md5_pkg::ST_RUN: begin
                if (round_reg == md5_pkg::LAST_BYTE) begin
                    state_next = md5_pkg::ST_FIN;
                end
            end
            md5_pkg::ST_FIN: begin
                case (mode_reg)
                    md5_pkg::MD_BLOCK:
                        state_next = emit_reg ? md5_pkg::ST_DSTART : md5_pkg::ST_IDLE;
                    md5_pkg::MD_PAD1:
                        state_next = (fill_reg >= md5_pkg::LEN_START) ? md5_pkg::ST_PREP
                                                                      : md5_pkg::ST_EMIT;
                    default: state_next = md5_pkg::ST_EMIT;
                endcase
            end
            md5_pkg::ST_EMIT: begin
                if (out_load && widx_reg == md5_pkg::LAST_WORD) begin
                    state_next = md5_pkg::ST_IDLE;
                end
            end
            default: state_next = md5_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        cmd_pop  = (state_reg == md5_pkg::ST_IDLE) && cmd_valid;
        out_load = (state_reg == md5_pkg::ST_EMIT) && (!m_valid_reg || m_ready);
        case (state_reg)
            md5_pkg::ST_RUN: rd_addr = md5_pkg::msg_idx(round_reg + 6'd1);
            default:         rd_addr = md5_pkg::msg_idx(6'd0);
        endcase
    end

    // message word for the current step, with padding and length laid over
    always_comb begin
        g        = md5_pkg::msg_idx(round_reg);
        m_word   = '0;
        len_here = (mode_reg == md5_pkg::MD_PAD2) || (fill_reg < md5_pkg::LEN_START);
        case (mode_reg)
            md5_pkg::MD_BLOCK: m_word = rd_data_reg;
            md5_pkg::MD_PAD1: begin
                for (int j = 0; j < 4; j++) begin
                    if ({g, 2'(j)} < fill_reg) begin
                        m_word[j*8 +: 8] = rd_data_reg[j*8 +: 8];
                    end else if ({g, 2'(j)} == fill_reg) begin
                        m_word[j*8 +: 8] = md5_pkg::PAD_BYTE;
                    end
                end
            end
            default: m_word = '0;
        endcase
        if (mode_reg != md5_pkg::MD_BLOCK && len_here) begin
            if (g == md5_pkg::LEN_LO_WRD) begin
                m_word = bit_count_reg[31:0];
            end else if (g == md5_pkg::LEN_HI_WRD) begin
                m_word = bit_count_reg[63:32];
            end
        end
    end

    // one compression step
    always_comb begin
        case (round_reg[5:4])
            2'd0:    f = (wb_reg & wc_reg) | (~wb_reg & wd_reg);
            2'd1:    f = (wb_reg & wd_reg) | (wc_reg & ~wd_reg);
            2'd2:    f = wb_reg ^ wc_reg ^ wd_reg;
            default: f = wc_reg ^ (wb_reg | ~wd_reg);
        endcase
        sum      = wa_reg + f + md5_pkg::round_k(round_reg) + m_word;
        rot_wide = {sum, sum} << md5_pkg::rot_amt(round_reg);
        new_b    = wb_reg + rot_wide[63:32];
    end

    // block buffer, byte writes, registered word read
    always_ff @(posedge aclk) begin
        if (cmd_pop && cmd.absorb) begin
            buf_mem[fill_reg[5:2]][fill_reg[1:0]*8 +: 8] <= cmd.data_byte;
        end
        rd_data_reg <= buf_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            md5_pkg::ST_DSTART: begin
                for (int k = 0; k < 4; k++) begin
                    hv_reg[k] <= cv_reg[k];
                end
            end
            md5_pkg::ST_PREP: begin
                if (mode_reg == md5_pkg::MD_BLOCK) begin
                    wa_reg <= cv_reg[0];
                    wb_reg <= cv_reg[1];
                    wc_reg <= cv_reg[2];
                    wd_reg <= cv_reg[3];
                end else begin
                    wa_reg <= hv_reg[0];
                    wb_reg <= hv_reg[1];
                    wc_reg <= hv_reg[2];
                    wd_reg <= hv_reg[3];
                end
            end
            md5_pkg::ST_RUN: begin
                wa_reg <= wd_reg;
                wb_reg <= new_b;
                wc_reg <= wb_reg;
                wd_reg <= wc_reg;
            end
            md5_pkg::ST_FIN: begin
                if (mode_reg != md5_pkg::MD_BLOCK) begin
                    hv_reg[0] <= hv_reg[0] + wa_reg;
                    hv_reg[1] <= hv_reg[1] + wb_reg;
                    hv_reg[2] <= hv_reg[2] + wc_reg;
                    hv_reg[3] <= hv_reg[3] + wd_reg;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_data_reg.digest_word <= hv_reg[widx_reg];
            m_data_reg.word_index  <= widx_reg;
            m_data_reg.last_word   <= (widx_reg == md5_pkg::LAST_WORD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= md5_pkg::ST_IDLE;
            mode_reg      <= md5_pkg::MD_BLOCK;
            cv_reg[0]     <= md5_pkg::IV_A;
            cv_reg[1]     <= md5_pkg::IV_B;
            cv_reg[2]     <= md5_pkg::IV_C;
            cv_reg[3]     <= md5_pkg::IV_D;
            bit_count_reg <= '0;
            fill_reg      <= '0;
            round_reg     <= '0;
            widx_reg      <= '0;
            emit_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                md5_pkg::ST_IDLE: begin
                    if (cmd_pop) begin
                        emit_reg    <= cmd.digest;
                        restart_reg <= cmd.restart;
                        mode_reg    <= md5_pkg::MD_BLOCK;
                        if (cmd.absorb) begin
                            bit_count_reg <= bit_count_reg + 64'd8;
                            fill_reg      <= fill_reg + 6'd1;
                        end
                    end
                end
                md5_pkg::ST_DSTART: mode_reg <= md5_pkg::MD_PAD1;
                md5_pkg::ST_PREP:   round_reg <= '0;
                md5_pkg::ST_RUN:    round_reg <= round_reg + 6'd1;
                md5_pkg::ST_FIN: begin
                    widx_reg <= '0;
                    if (mode_reg == md5_pkg::MD_BLOCK) begin
                        cv_reg[0] <= cv_reg[0] + wa_reg;
                        cv_reg[1] <= cv_reg[1] + wb_reg;
                        cv_reg[2] <= cv_reg[2] + wc_reg;
                        cv_reg[3] <= cv_reg[3] + wd_reg;
                    end else if (mode_reg == md5_pkg::MD_PAD1
                                 && fill_reg >= md5_pkg::LEN_START) begin
                        mode_reg <= md5_pkg::MD_PAD2;
                    end
                end
                md5_pkg::ST_EMIT: begin
                    if (out_load) begin
                        widx_reg <= widx_reg + 2'd1;
                        if (widx_reg == md5_pkg::LAST_WORD && restart_reg) begin
                            cv_reg[0]     <= md5_pkg::IV_A;
                            cv_reg[1]     <= md5_pkg::IV_B;
                            cv_reg[2]     <= md5_pkg::IV_C;
                            cv_reg[3]     <= md5_pkg::IV_D;
                            bit_count_reg <= '0;
                            fill_reg      <= '0;
                        end
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_data_reg;

`ifndef SYNTHESIS
    a_full_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_pop && block_full) |=>
            (state_reg == md5_pkg::ST_PREP && mode_reg == md5_pkg::MD_BLOCK))
        else $error("full block not sent to compression");

    a_pad2_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == md5_pkg::ST_RUN && mode_reg == md5_pkg::MD_PAD2) |->
            (fill_reg >= md5_pkg::LEN_START))
        else $error("extra padding block without cause");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.last_word == (m_result.word_index == md5_pkg::LAST_WORD)))
        else $error("last_word out of step with word_index");
`endif

endmodule
